>>> src/sipq_pkg.sv
package sipq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W = 34;
    localparam int TAG_W = 32;
    localparam int ENTRIES_W = 5;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [KEY_W-1:0]     out_key;
        logic [TAG_W-1:0]     out_tag;
        logic [ENTRIES_W-1:0] entries;
        logic                 became_empty;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

endpackage

>>> src/sorted_insert_priority_queue.sv
// Bounded priority queue that holds up to DEPTH (key, tag) entries in ascending key order
// in a circular buffer memory. Every item yields exactly one result. A dequeue on an empty
// queue, and any enqueue on an empty or full queue, registers its result on acceptance; a
// dequeue that removes an entry does so from S_DEQ once the head entry is read. An enqueue
// into a queue holding n entries walks back from the tail one entry per cycle, moving each
// larger key, and each equal key but the head, one place back through the single memory
// read and write port. The block takes no new item while an item is in progress, or while
// a result waits in the output register and the result channel is not ready in that cycle.
module sorted_insert_priority_queue #(
    parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sipq_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sipq_pkg::out_item_t m_data
);
    import sipq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    pos_reg, pos_next;
    entry_t           new_reg, new_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             out_free;
    logic             accept;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    entry_t           wr_data;
    logic [AW-1:0]    rd_addr;
    entry_t           rd_data;
    logic             move_back;

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(off);
        if (sum >= (CW + 1)'(DEPTH)) begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    sipq_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign move_back = (pos_reg > CW'(1)) ? (rd_data.key >= new_reg.key)
                                          : (rd_data.key > new_reg.key);

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        new_next     = new_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_addr      = ring_addr(head_reg, pos_reg);
        wr_data      = new_reg;
        rd_addr      = ring_addr(head_reg, pos_reg - CW'(2));

        case (state_reg)
            S_IDLE: begin
                if (s_data.command == CMD_ENQUEUE) begin
                    rd_addr = ring_addr(head_reg, count_reg - CW'(1));
                end else begin
                    rd_addr = head_reg;
                end
                if (accept) begin
                    m_data_next = '0;
                    if (s_data.command == CMD_ENQUEUE) begin
                        new_next.key = s_data.key;
                        new_next.tag = s_data.tag;
                        if (count_reg == CW'(DEPTH)) begin
                            m_valid_next        = 1'b1;
                            m_data_next.status  = ST_FULL;
                            m_data_next.entries = ENTRIES_W'(count_reg);
                        end else if (count_reg == '0) begin
                            wr_en               = 1'b1;
                            wr_addr             = head_reg;
                            wr_data.key         = s_data.key;
                            wr_data.tag         = s_data.tag;
                            count_next          = CW'(1);
                            m_valid_next        = 1'b1;
                            m_data_next.status  = ST_INSERTED;
                            m_data_next.entries = ENTRIES_W'(CW'(1));
                        end else begin
                            pos_next   = count_reg;
                            state_next = S_SCAN;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            m_valid_next       = 1'b1;
                            m_data_next.status = ST_EMPTY;
                        end else begin
                            state_next = S_DEQ;
                        end
                    end
                end
            end
            S_SCAN: begin
                wr_en = 1'b1;
                if (pos_reg != '0 && move_back) begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - CW'(1);
                end else begin
                    count_next          = count_reg + CW'(1);
                    m_valid_next        = 1'b1;
                    m_data_next         = '0;
                    m_data_next.status  = ST_INSERTED;
                    m_data_next.entries = ENTRIES_W'(count_reg + CW'(1));
                    state_next          = S_IDLE;
                end
            end
            S_DEQ: begin
                head_next                = ring_addr(head_reg, CW'(1));
                count_next               = count_reg - CW'(1);
                m_valid_next             = 1'b1;
                m_data_next.status       = ST_REMOVED;
                m_data_next.out_key      = rd_data.key;
                m_data_next.out_tag      = rd_data.tag;
                m_data_next.entries      = ENTRIES_W'(count_reg - CW'(1));
                m_data_next.became_empty = (count_reg == CW'(1));
                state_next               = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg    <= pos_next;
        new_reg    <= new_next;
        m_data_reg <= m_data_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the queue depth");

    a_scan_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (pos_reg <= count_reg))
        else $error("insert position lies beyond the tail");

    a_entries_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.entries == ENTRIES_W'(count_reg)))
        else $error("reported entry count disagrees with the held count");

    a_removed_emptied: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == ST_REMOVED)
            |-> (m_data_reg.became_empty == (count_reg == '0)))
        else $error("emptied flag disagrees with the held count");

endmodule

>>> src/sipq_store.sv
module sipq_store #(
    parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  sipq_pkg::entry_t           wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output sipq_pkg::entry_t           rd_data
);
    import sipq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
